// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cosine similarity score unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define CSIM_ASSERT(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error("csim assertion failed");

// consequent holds whenever the antecedent holds
`define CSIM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("csim assertion failed");

`endif

// ===== src/csim_pkg.sv =====
// ---------------------------------------------------------------------------
// csim_pkg
// Types and constants shared by the cosine similarity score unit.
// ---------------------------------------------------------------------------
package csim_pkg;

  localparam int ELEM_BITS   = 16;
  localparam int PROD_BITS   = 2 * ELEM_BITS;
  localparam int SQ_BITS     = 2 * ELEM_BITS - 1;
  localparam int DOT_BITS    = 38;
  localparam int NORM_BITS   = 37;
  localparam int SCORE_BITS  = 13;
  localparam int SCORE_SCALE = 2500;
  localparam int SCALE_BITS  = 12;
  localparam int MAG_BITS    = DOT_BITS;
  localparam int OPND_BITS   = MAG_BITS + SCALE_BITS;
  localparam int WIDE_BITS   = 2 * OPND_BITS;
  localparam int ROOT_BITS   = 12;
  localparam int ROOT_IDX    = $clog2(ROOT_BITS);
  localparam int AB_SHIFT    = 2 * (ROOT_BITS - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] element_a;
    logic signed [ELEM_BITS-1:0] element_b;
    logic                        last_element;
  } in_t;

  typedef struct packed {
    logic signed [SCORE_BITS-1:0] similarity;
    logic                         zero_norm;
  } out_t;

  typedef struct packed {
    logic [DOT_BITS-1:0]  dot;
    logic [NORM_BITS-1:0] norm_a;
    logic [NORM_BITS-1:0] norm_b;
  } job_t;

  typedef struct packed {
    logic                 start;
    logic [OPND_BITS-1:0] mcand;
    logic [OPND_BITS-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic [WIDE_BITS-1:0] product;
  } mul_rsp_t;

endpackage

// ===== src/csim_front.sv =====
// ---------------------------------------------------------------------------
// csim_front
// Two-stage accumulator: registers the element products, then adds them
// into the running sums and hands a finished vector to the job queue.
// ---------------------------------------------------------------------------
module csim_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  csim_pkg::in_t  in_data,
  output logic           job_push,
  output csim_pkg::job_t job_data,
  input  logic           job_full
);
  import csim_pkg::*;

  logic                        vld_r;
  logic                        last_r;
  logic signed [PROD_BITS-1:0] prod_dot_r;
  logic [SQ_BITS-1:0]          sq_a_r;
  logic [SQ_BITS-1:0]          sq_b_r;
  logic [DOT_BITS-1:0]         dot_sum_r;
  logic [NORM_BITS-1:0]        norm_a_sum_r;
  logic [NORM_BITS-1:0]        norm_b_sum_r;

  logic                        stall;
  logic                        accept;
  logic signed [PROD_BITS-1:0] prod_dot;
  logic signed [PROD_BITS-1:0] prod_aa;
  logic signed [PROD_BITS-1:0] prod_bb;
  logic [DOT_BITS-1:0]         dot_nxt;
  logic [NORM_BITS-1:0]        norm_a_nxt;
  logic [NORM_BITS-1:0]        norm_b_nxt;

  always_comb begin
    stall    = vld_r & last_r & job_full;
    full     = stall;
    accept   = push & ~stall;
    prod_dot = PROD_BITS'(in_data.element_a) * PROD_BITS'(in_data.element_b);
    prod_aa  = PROD_BITS'(in_data.element_a) * PROD_BITS'(in_data.element_a);
    prod_bb  = PROD_BITS'(in_data.element_b) * PROD_BITS'(in_data.element_b);
    dot_nxt  = dot_sum_r + {{(DOT_BITS-PROD_BITS){prod_dot_r[PROD_BITS-1]}}, prod_dot_r};
    norm_a_nxt = norm_a_sum_r + {{(NORM_BITS-SQ_BITS){1'b0}}, sq_a_r};
    norm_b_nxt = norm_b_sum_r + {{(NORM_BITS-SQ_BITS){1'b0}}, sq_b_r};
    job_push        = vld_r & last_r & ~job_full;
    job_data.dot    = dot_nxt;
    job_data.norm_a = norm_a_nxt;
    job_data.norm_b = norm_b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= 1'b0;
      dot_sum_r    <= '0;
      norm_a_sum_r <= '0;
      norm_b_sum_r <= '0;
    end else begin
      if (!stall) begin
        vld_r <= accept;
      end
      if (vld_r && !stall) begin
        // clear the sums once the last pair has gone to the queue
        if (last_r) begin
          dot_sum_r    <= '0;
          norm_a_sum_r <= '0;
          norm_b_sum_r <= '0;
        end else begin
          dot_sum_r    <= dot_nxt;
          norm_a_sum_r <= norm_a_nxt;
          norm_b_sum_r <= norm_b_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r     <= in_data.last_element;
      prod_dot_r <= prod_dot;
      sq_a_r     <= prod_aa[SQ_BITS-1:0];
      sq_b_r     <= prod_bb[SQ_BITS-1:0];
    end
  end

endmodule

// ===== src/csim_queue.sv =====
// ---------------------------------------------------------------------------
// csim_queue
// Short job queue between the accumulator and the scoring engine.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csim_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  csim_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output csim_pkg::job_t pop_data,
  output logic           empty
);
  import csim_pkg::*;

  job_t                 entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;
  logic                 do_push;
  logic                 do_pop;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_BITS'(1);
  endfunction

  always_comb begin
    full     = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
    empty    = (cnt_r == '0);
    do_push  = push & ~full;
    do_pop   = pop & ~empty;
    pop_data = entry_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  `CSIM_ASSERT(a_q_cnt_bound, clk, rst_n, cnt_r <= QCNT_BITS'(QUEUE_DEPTH))
  `CSIM_ASSERT_IMP(a_q_no_push_full, clk, rst_n, push, !full)

endmodule

// ===== src/csim_mul.sv =====
// ---------------------------------------------------------------------------
// csim_mul
// Shift-add multiplier, one multiplier bit per cycle, stops early once the
// remaining multiplier bits are all zero.
// ---------------------------------------------------------------------------
module csim_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  csim_pkg::mul_req_t req,
  output csim_pkg::mul_rsp_t rsp
);
  import csim_pkg::*;

  logic                 busy_r;
  logic [WIDE_BITS-1:0] acc_r;
  logic [WIDE_BITS-1:0] mcand_r;
  logic [OPND_BITS-1:0] mplier_r;

  always_comb begin
    rsp.done    = busy_r & (mplier_r == '0);
    rsp.product = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && mplier_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r    <= '0;
      mcand_r  <= {{(WIDE_BITS-OPND_BITS){1'b0}}, req.mcand};
      mplier_r <= req.mplier;
    end else if (busy_r && mplier_r != '0) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

endmodule

// ===== src/csim_back.sv =====
// ---------------------------------------------------------------------------
// csim_back
// Scoring engine: forms A*B and (2500*|dot|)^2 on the shared multiplier,
// finds the 12-bit root bit by bit with shift-add updates, applies the sign
// and clamp, and holds the score in an output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csim_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_empty,
  input  csim_pkg::job_t job_data,
  output logic           job_pop,
  output logic           empty,
  input  logic           pop,
  output csim_pkg::out_t out_data
);
  import csim_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL_AB = 8'b0000_0010,
    S_MUL_C  = 8'b0000_0100,
    S_MUL_R  = 8'b0000_1000,
    S_SQ_ADD = 8'b0001_0000,
    S_SQ_CMP = 8'b0010_0000,
    S_SCORE  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t                state_r;
  logic                  start_r;
  logic [OPND_BITS-1:0]  mcand_r;
  logic [OPND_BITS-1:0]  mplier_r;
  mul_rsp_t              rsp;
  logic                  neg_r;
  logic [WIDE_BITS-1:0]  r_r;
  logic [WIDE_BITS-1:0]  x_r;
  logic [WIDE_BITS-1:0]  yk_r;
  logic [WIDE_BITS-1:0]  abs_r;
  logic [WIDE_BITS-1:0]  t_r;
  logic [ROOT_BITS-1:0]  root_r;
  logic [ROOT_IDX-1:0]   bit_r;
  out_t                  res_r;
  out_t                  out_r;
  logic                  out_vld_r;

  mul_req_t              mul_req;
  logic                  neg_in;
  logic [MAG_BITS-1:0]   mag_in;
  logic                  zero_in;
  logic                  fit;
  logic [WIDE_BITS-1:0]  yk_upd;
  logic                  exact;
  logic [SCORE_BITS-1:0] ceil_root;
  logic [SCORE_BITS-1:0] clamped;
  logic [SCORE_BITS-1:0] score;
  logic                  load_out;

  csim_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (rsp)
  );

  always_comb begin
    mul_req = '{start: start_r, mcand: mcand_r, mplier: mplier_r};
    job_pop = (state_r == S_IDLE) & ~job_empty;
    neg_in  = job_data.dot[DOT_BITS-1];
    mag_in  = neg_in ? (~job_data.dot + MAG_BITS'(1)) : job_data.dot;
    zero_in = (job_data.norm_a == '0) | (job_data.norm_b == '0);

    fit    = (t_r <= r_r);
    yk_upd = fit ? (yk_r + (abs_r << 1)) : yk_r;

    // negative dot: round the root up unless the square matches exactly
    exact     = (x_r == r_r);
    ceil_root = {1'b0, root_r} + SCORE_BITS'(neg_r & ~exact);
    clamped   = (ceil_root > SCORE_BITS'(SCORE_SCALE)) ? SCORE_BITS'(SCORE_SCALE)
                                                       : ceil_root;
    score     = neg_r ? (SCORE_BITS'(0) - clamped) : clamped;

    load_out = (state_r == S_DONE) & (~out_vld_r | pop);
    empty    = ~out_vld_r;
    out_data = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      start_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!job_empty) begin
            if (zero_in) begin
              state_r <= S_DONE;
            end else begin
              start_r <= 1'b1;
              state_r <= S_MUL_AB;
            end
          end
        end
        S_MUL_AB: begin
          if (rsp.done) begin
            start_r <= 1'b1;
            state_r <= S_MUL_C;
          end
        end
        S_MUL_C: begin
          if (rsp.done) begin
            start_r <= 1'b1;
            state_r <= S_MUL_R;
          end
        end
        S_MUL_R: begin
          if (rsp.done) begin
            state_r <= S_SQ_ADD;
          end
        end
        S_SQ_ADD: begin
          state_r <= S_SQ_CMP;
        end
        S_SQ_CMP: begin
          state_r <= (bit_r == '0) ? S_SCORE : S_SQ_ADD;
        end
        S_SCORE: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        neg_r    <= neg_in;
        res_r    <= '{similarity: '0, zero_norm: 1'b1};
        mcand_r  <= {{(OPND_BITS-NORM_BITS){1'b0}}, job_data.norm_a};
        mplier_r <= {{(OPND_BITS-NORM_BITS){1'b0}}, job_data.norm_b};
        // hold the magnitude in x_r until the scaling multiply
        x_r      <= {{(WIDE_BITS-MAG_BITS){1'b0}}, mag_in};
      end
      S_MUL_AB: begin
        if (rsp.done) begin
          abs_r    <= rsp.product << AB_SHIFT;
          mcand_r  <= x_r[OPND_BITS-1:0];
          mplier_r <= OPND_BITS'(SCORE_SCALE);
        end
      end
      S_MUL_C: begin
        if (rsp.done) begin
          mcand_r  <= rsp.product[OPND_BITS-1:0];
          mplier_r <= rsp.product[OPND_BITS-1:0];
        end
      end
      S_MUL_R: begin
        if (rsp.done) begin
          r_r    <= rsp.product;
          x_r    <= '0;
          yk_r   <= '0;
          root_r <= '0;
          bit_r  <= ROOT_IDX'(ROOT_BITS - 1);
        end
      end
      S_SQ_ADD: begin
        t_r <= x_r + yk_r + abs_r;
      end
      S_SQ_CMP: begin
        // keep the trial bit when its square still fits
        if (fit) begin
          x_r           <= t_r;
          root_r[bit_r] <= 1'b1;
        end
        yk_r  <= yk_upd >> 1;
        abs_r <= abs_r >> 2;
        bit_r <= bit_r - ROOT_IDX'(1);
      end
      S_SCORE: begin
        res_r <= '{similarity: score, zero_norm: 1'b0};
      end
      S_DONE: begin
        if (load_out) begin
          out_r <= res_r;
        end
      end
      default: begin
      end
    endcase
  end

  `CSIM_ASSERT_IMP(a_b_zero_score, clk, rst_n, out_vld_r && out_r.zero_norm,
                   out_r.similarity == '0)
  `CSIM_ASSERT_IMP(a_b_score_range, clk, rst_n, out_vld_r,
                   ($signed(out_r.similarity) <= $signed(SCORE_BITS'(SCORE_SCALE))) &&
                   ($signed(out_r.similarity) >= -$signed(SCORE_BITS'(SCORE_SCALE))))

endmodule

// ===== src/cosine_similarity_score_unit.sv =====
// ---------------------------------------------------------------------------
// cosine_similarity_score_unit
// Input: one pair per cycle unless full; products are registered, then summed.
// Score: bounded by the bit-serial multiplier (at most 37 + 12 + 49 bit steps)
// and 12 root steps, each an add state and a compare state; the back end scores
// one vector at a time, with a 2-entry job queue in between.
// Reset (synchronous, rst_n low) clears the sums, the queue and the result.
// ---------------------------------------------------------------------------
module cosine_similarity_score_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  csim_pkg::in_t  in_data,
  output logic           empty,
  input  logic           pop,
  output csim_pkg::out_t out_data
);
  import csim_pkg::*;

  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;
  job_t job_in;
  job_t job_out;

  csim_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .job_push (job_push),
    .job_data (job_in),
    .job_full (job_full)
  );

  csim_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  csim_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
